/* rtl/kea_pkg.sv */
package kea_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VERTEX_W = $clog2(MAX_VERTICES);
  localparam int COST_W   = 32;
  localparam int COUNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_ACCEPT  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CYCLE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADV    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RESTART = 3'd4;

  localparam logic MODE_EDGE    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  localparam logic [2:0] ADDR_VERTEX_COUNT = 3'd0;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef struct packed {
    logic                      mode;
    logic                      bad_vertex;
    logic [VERTEX_W-1:0]       u;
    logic [VERTEX_W-1:0]       v;
    logic signed [COST_W-1:0]  cost;
  } kea_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        components;
    logic [VERTEX_W-1:0]       u;
    logic [VERTEX_W-1:0]       v;
    logic signed [COST_W-1:0]  cost;
  } kea_result_t;

endpackage

/* rtl/kea_front.sv */
module kea_front
  import kea_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     init_busy,
  input  logic [COUNT_W-1:0]       eff_count,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic [VERTEX_W-1:0]      in_vertex_u,
  input  logic [VERTEX_W-1:0]      in_vertex_v,
  input  logic signed [COST_W-1:0] in_edge_cost,
  output logic                     push_valid,
  input  logic                     push_ready,
  output kea_item_t                push_item
);

  logic      hold_valid_r;
  kea_item_t item_r;
  logic      in_take;
  logic      bad_u;
  logic      bad_v;

  assign in_ready   = (!hold_valid_r || push_ready) && !init_busy;
  assign in_take    = in_valid && in_ready;
  assign push_valid = hold_valid_r;
  assign push_item  = item_r;

  assign bad_u = {1'b0, in_vertex_u} >= eff_count;
  assign bad_v = {1'b0, in_vertex_v} >= eff_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_take) begin
      hold_valid_r <= 1'b1;
    end else if (push_ready) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.mode       <= in_mode;
      item_r.bad_vertex <= bad_u || bad_v;
      item_r.u          <= in_vertex_u;
      item_r.v          <= in_vertex_v;
      item_r.cost       <= in_edge_cost;
    end
  end

endmodule

/* rtl/kea_queue.sv */
module kea_queue
  import kea_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  kea_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output kea_item_t pop_item
);

  kea_item_t         entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   fill_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill_r != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = fill_r != '0;
  assign pop_item   = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/kea_back.sv */
module kea_back
  import kea_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [COUNT_W-1:0] eff_count,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  kea_item_t          pop_item,
  output logic               init_busy,
  output logic               out_valid,
  input  logic               out_ready,
  output kea_result_t        out_result
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam logic [NW-1:0] END_MARK = NW'(MAX_VERTICES);
  localparam logic [VW-1:0] LAST_IDX = VW'(MAX_VERTICES - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LAB   = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_SEL   = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_RES   = 3'd6;

  logic [VW-1:0] label_mem [MAX_VERTICES];
  logic [NW-1:0] next_mem  [MAX_VERTICES];
  logic [NW-1:0] size_mem  [MAX_VERTICES];
  logic [VW-1:0] head_mem  [MAX_VERTICES];

  logic          lab_we;
  logic [VW-1:0] lab_wa, lab_wd, lab_ra0, lab_ra1;
  logic [VW-1:0] lab_rd0_r, lab_rd1_r;
  logic          nxt_we;
  logic [VW-1:0] nxt_wa, nxt_ra;
  logic [NW-1:0] nxt_wd, nxt_rd_r;
  logic          size_we;
  logic [VW-1:0] size_wa, size_ra0, size_ra1;
  logic [NW-1:0] size_wd, size_rd0_r, size_rd1_r;
  logic          head_we;
  logic [VW-1:0] head_wa, head_wd, head_ra0, head_ra1;
  logic [VW-1:0] head_rd0_r, head_rd1_r;

  logic [2:0]          state_r, state_nxt;
  logic [VW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                restart_r, restart_nxt;
  kea_item_t           item_r, item_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [VW-1:0]       src_head_r, src_head_nxt;
  logic [VW-1:0]       dst_r, dst_nxt;
  logic [VW-1:0]       dst_head_r, dst_head_nxt;
  logic [VW-1:0]       cur_r, cur_nxt;
  logic                first_r, first_nxt;
  logic                out_valid_r;
  kea_result_t         out_res_r;
  logic                out_load;
  logic                out_free;
  logic [VW-1:0]       cur_walk;
  logic                walk_end;

  assign out_free   = !out_valid_r || out_ready;
  assign cur_walk   = first_r ? src_head_r : nxt_rd_r[VW-1:0];
  assign walk_end   = !first_r && (nxt_rd_r >= END_MARK);
  assign init_busy  = (state_r == S_CLEAR) && !restart_r;
  assign out_valid  = out_valid_r;
  assign out_result = out_res_r;

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    restart_nxt  = restart_r;
    item_nxt     = item_r;
    status_nxt   = status_r;
    count_nxt    = count_r;
    src_head_nxt = src_head_r;
    dst_nxt      = dst_r;
    dst_head_nxt = dst_head_r;
    cur_nxt      = cur_r;
    first_nxt    = first_r;
    pop_ready    = 1'b0;
    out_load     = 1'b0;
    lab_we       = 1'b0;
    lab_wa       = cur_walk;
    lab_wd       = dst_r;
    lab_ra0      = VW'(item_r.u);
    lab_ra1      = VW'(item_r.v);
    nxt_we       = 1'b0;
    nxt_wa       = cur_r;
    nxt_wd       = NW'(dst_head_r);
    nxt_ra       = cur_walk;
    size_we      = 1'b0;
    size_wa      = dst_r;
    size_wd      = size_rd0_r + size_rd1_r;
    size_ra0     = lab_rd0_r;
    size_ra1     = lab_rd1_r;
    head_we      = 1'b0;
    head_wa      = dst_r;
    head_wd      = src_head_r;
    head_ra0     = lab_rd0_r;
    head_ra1     = lab_rd1_r;

    unique case (state_r)
      S_CLEAR: begin
        lab_we  = 1'b1;
        lab_wa  = clr_cnt_r;
        lab_wd  = clr_cnt_r;
        nxt_we  = 1'b1;
        nxt_wa  = clr_cnt_r;
        nxt_wd  = END_MARK;
        size_we = 1'b1;
        size_wa = clr_cnt_r;
        size_wd = NW'(1);
        head_we = 1'b1;
        head_wa = clr_cnt_r;
        head_wd = clr_cnt_r;
        if (clr_cnt_r == LAST_IDX) begin
          clr_cnt_nxt = '0;
          count_nxt   = eff_count;
          if (restart_r) begin
            status_nxt = ST_RESTART;
            state_nxt  = S_RES;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          item_nxt = pop_item;
          if (pop_item.mode == MODE_RESTART) begin
            restart_nxt = 1'b1;
            clr_cnt_nxt = '0;
            state_nxt   = S_CLEAR;
          end else if (count_r <= COUNT_W'(1)) begin
            status_nxt = ST_DONE;
            state_nxt  = S_RES;
          end else if (pop_item.bad_vertex) begin
            status_nxt = ST_BADV;
            state_nxt  = S_RES;
          end else begin
            state_nxt = S_LAB;
          end
        end
      end
      S_LAB: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (lab_rd0_r == lab_rd1_r) begin
          status_nxt = ST_CYCLE;
          state_nxt  = S_RES;
        end else begin
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        // larger set keeps its label, ties go to the second endpoint's set
        if (size_rd0_r > size_rd1_r) begin
          dst_nxt      = lab_rd0_r;
          src_head_nxt = head_rd1_r;
          dst_head_nxt = head_rd0_r;
          head_wd      = head_rd1_r;
          size_wa      = lab_rd0_r;
          head_wa      = lab_rd0_r;
        end else begin
          dst_nxt      = lab_rd1_r;
          src_head_nxt = head_rd0_r;
          dst_head_nxt = head_rd1_r;
          head_wd      = head_rd0_r;
          size_wa      = lab_rd1_r;
          head_wa      = lab_rd1_r;
        end
        size_we   = 1'b1;
        head_we   = 1'b1;
        first_nxt = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (walk_end) begin
          nxt_we     = 1'b1;
          count_nxt  = count_r - COUNT_W'(1);
          status_nxt = ST_ACCEPT;
          first_nxt  = 1'b1;
          state_nxt  = S_RES;
        end else begin
          lab_we    = 1'b1;
          cur_nxt   = cur_walk;
          first_nxt = 1'b0;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_load    = 1'b1;
          restart_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (lab_we) begin
      label_mem[lab_wa] <= lab_wd;
    end
    lab_rd0_r <= label_mem[lab_ra0];
    lab_rd1_r <= label_mem[lab_ra1];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      next_mem[nxt_wa] <= nxt_wd;
    end
    nxt_rd_r <= next_mem[nxt_ra];
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_wa] <= size_wd;
    end
    size_rd0_r <= size_mem[size_ra0];
    size_rd1_r <= size_mem[size_ra1];
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd0_r <= head_mem[head_ra0];
    head_rd1_r <= head_mem[head_ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      restart_r   <= 1'b0;
      count_r     <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      restart_r <= restart_nxt;
      count_r   <= count_nxt;
      first_r   <= first_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    status_r   <= status_nxt;
    src_head_r <= src_head_nxt;
    dst_r      <= dst_nxt;
    dst_head_r <= dst_head_nxt;
    cur_r      <= cur_nxt;
    if (out_load) begin
      out_res_r.status     <= status_r;
      out_res_r.components <= count_r;
      out_res_r.u          <= item_r.u;
      out_res_r.v          <= item_r.v;
      out_res_r.cost       <= item_r.cost;
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !(pop_valid && pop_ready))
    else $error("word taken from queue during clearing pass");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (count_r != '0))
    else $error("component count is zero");

  a_accept_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && walk_end) |=> (count_r == $past(count_r) - COUNT_W'(1)))
    else $error("accepted edge did not drop the component count");

  a_merge_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEL) |-> (lab_rd0_r != lab_rd1_r))
    else $error("merge of a set into itself");

endmodule

/* rtl/kruskal_edge_acceptance_core.sv */
// an ignored or bad-vertex word and a rejected cycle skip the relabel walk; an accepted edge
// walks the m members of the smaller set, one member per cycle, over the next-member memory;
// this walk sets the throughput (m at most MAX_VERTICES/2); a restart reruns the clearing pass
// reset: synchronous, active low; a clearing pass over all MAX_VERTICES entries follows,
// with in_ready low
module kruskal_edge_acceptance_core
  import kea_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic [VERTEX_W-1:0]      in_vertex_u,
  input  logic [VERTEX_W-1:0]      in_vertex_v,
  input  logic signed [COST_W-1:0] in_edge_cost,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [COUNT_W-1:0]       out_components_left,
  output logic [VERTEX_W-1:0]      out_tree_u,
  output logic [VERTEX_W-1:0]      out_tree_v,
  output logic signed [COST_W-1:0] out_tree_cost
);

  logic [COUNT_W-1:0] vertex_count_r;
  logic [COUNT_W-1:0] eff_count;
  logic               init_busy;
  logic               push_valid, push_ready;
  kea_item_t          push_item;
  logic               pop_valid, pop_ready;
  kea_item_t          pop_item;
  kea_result_t        result;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_VERTEX_COUNT) ? 32'(vertex_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= COUNT_W'(64);
    end else if (psel && penable && pwrite && pready && paddr == ADDR_VERTEX_COUNT) begin
      vertex_count_r <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    if (vertex_count_r < COUNT_W'(2)) begin
      eff_count = COUNT_W'(2);
    end else if (int'(vertex_count_r) > MAX_VERTICES) begin
      eff_count = COUNT_W'(MAX_VERTICES);
    end else begin
      eff_count = vertex_count_r;
    end
  end

  kea_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .init_busy    (init_busy),
    .eff_count    (eff_count),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_vertex_u  (in_vertex_u),
    .in_vertex_v  (in_vertex_v),
    .in_edge_cost (in_edge_cost),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  kea_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  kea_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_count  (eff_count),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (result)
  );

  assign out_status          = result.status;
  assign out_components_left = result.components;
  assign out_tree_u          = result.u;
  assign out_tree_v          = result.v;
  assign out_tree_cost       = result.cost;

endmodule

/* test/kruskal_edge_acceptance_checker.sv */
`timescale 1ns / 100ps

module kruskal_edge_acceptance_checker
  import kea_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  input  logic                     pready,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_mode,
  input  logic [VERTEX_W-1:0]      in_vertex_u,
  input  logic [VERTEX_W-1:0]      in_vertex_v,
  input  logic signed [COST_W-1:0] in_edge_cost,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [STATUS_W-1:0]      out_status,
  input  logic [COUNT_W-1:0]       out_components_left,
  input  logic [VERTEX_W-1:0]      out_tree_u,
  input  logic [VERTEX_W-1:0]      out_tree_v,
  input  logic signed [COST_W-1:0] out_tree_cost,
  output int                       mismatch_count,
  output int                       words_pending
);

  localparam logic [COUNT_W-1:0] END_OF_LIST = COUNT_W'(MAX_VERTICES);
  localparam int MAX_REPORTS = 100;

  logic [VERTEX_W-1:0] member_label [MAX_VERTICES];
  logic [COUNT_W-1:0]  member_link  [MAX_VERTICES];
  logic [COUNT_W-1:0]  set_members  [MAX_VERTICES];
  logic [VERTEX_W-1:0] set_first    [MAX_VERTICES];
  logic [COUNT_W-1:0]  sets_left;
  logic [COUNT_W-1:0]  vertex_limit_reg;
  kea_result_t         expected_words [$];

  initial begin
    mismatch_count = 0;
    words_pending  = 0;
  end

  function automatic int usable_vertices();
    int n;
    n = int'(vertex_limit_reg);
    if (n < 2) n = 2;
    if (n > MAX_VERTICES) n = MAX_VERTICES;
    return n;
  endfunction

  function automatic void make_singletons();
    for (int i = 0; i < MAX_VERTICES; i++) begin
      member_label[i] = VERTEX_W'(i);
      member_link[i]  = END_OF_LIST;
      set_members[i]  = COUNT_W'(1);
      set_first[i]    = VERTEX_W'(i);
    end
    sets_left = COUNT_W'(usable_vertices());
  endfunction

  // relabel the members of src, then splice its list in front of dst
  function automatic void splice_set(input int src, input int dst);
    int walk;
    int steps;
    bit at_tail;
    walk    = int'(set_first[src]);
    steps   = 0;
    at_tail = 1'b0;
    while (!at_tail && steps < MAX_VERTICES) begin
      member_label[walk] = VERTEX_W'(dst);
      if (member_link[walk] >= END_OF_LIST) begin
        at_tail = 1'b1;
      end else begin
        walk = int'(member_link[walk]);
      end
      steps++;
    end
    member_link[walk] = COUNT_W'(set_first[dst]);
    set_first[dst]    = set_first[src];
    set_members[dst]  = set_members[dst] + set_members[src];
  endfunction

  function automatic kea_result_t predict_word(input logic mode,
                                               input logic [VERTEX_W-1:0] u,
                                               input logic [VERTEX_W-1:0] v,
                                               input logic signed [COST_W-1:0] cost);
    kea_result_t word;
    int n;
    int a;
    int b;
    n = usable_vertices();
    if (mode == MODE_RESTART) begin
      make_singletons();
      word.status = ST_RESTART;
    end else if (sets_left <= COUNT_W'(1)) begin
      word.status = ST_DONE;
    end else if (int'(u) >= n || int'(v) >= n) begin
      word.status = ST_BADV;
    end else begin
      a = int'(member_label[u]);
      b = int'(member_label[v]);
      if (a == b) begin
        word.status = ST_CYCLE;
      end else begin
        if (set_members[a] > set_members[b]) begin
          splice_set(b, a);
        end else begin
          splice_set(a, b);
        end
        sets_left   = sets_left - COUNT_W'(1);
        word.status = ST_ACCEPT;
      end
    end
    word.components = sets_left;
    word.u          = u;
    word.v          = v;
    word.cost       = cost;
    return word;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin : track
    kea_result_t want;
    if (!rst_n) begin
      vertex_limit_reg = COUNT_W'(MAX_VERTICES);
      make_singletons();
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_VERTEX_COUNT) begin
        vertex_limit_reg = pwdata[COUNT_W-1:0];
      end
      if (in_valid && in_ready) begin
        expected_words.push_back(predict_word(in_mode, in_vertex_u, in_vertex_v,
                                              in_edge_cost));
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, status", out_status, 0);
        end else begin
          want = expected_words.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_components_left !== want.components)
            report_mismatch("components_left", out_components_left, want.components);
          if (out_tree_u !== want.u)
            report_mismatch("tree_u", out_tree_u, want.u);
          if (out_tree_v !== want.v)
            report_mismatch("tree_v", out_tree_v, want.v);
          if (out_tree_cost !== want.cost)
            report_mismatch("tree_cost", out_tree_cost, want.cost);
        end
      end
    end
    words_pending = expected_words.size();
  end

endmodule

/* test/kruskal_edge_acceptance_core_test.sv */
`timescale 1ns / 100ps

module kruskal_edge_acceptance_core_test;
  import kea_pkg::*;

  localparam int RANDOM_WORDS     = 1000;
  localparam int CALM_WORDS       = 120;
  localparam int SETTLE_CYCLES    = 16;
  localparam int DRAIN_CYCLES     = 100;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT      = 1000000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [2:0]               paddr = ADDR_VERTEX_COUNT;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_mode = MODE_EDGE;
  logic [VERTEX_W-1:0]      in_vertex_u = '0;
  logic [VERTEX_W-1:0]      in_vertex_v = '0;
  logic signed [COST_W-1:0] in_edge_cost = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b1;
  logic [STATUS_W-1:0]      out_status;
  logic [COUNT_W-1:0]       out_components_left;
  logic [VERTEX_W-1:0]      out_tree_u;
  logic [VERTEX_W-1:0]      out_tree_v;
  logic signed [COST_W-1:0] out_tree_cost;

  int mismatch_count;
  int words_pending;
  int cycle_count = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  bit long_hold_req = 1'b0;
  int vertices_in_use = MAX_VERTICES;

  kruskal_edge_acceptance_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_vertex_u        (in_vertex_u),
    .in_vertex_v        (in_vertex_v),
    .in_edge_cost       (in_edge_cost),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_components_left(out_components_left),
    .out_tree_u         (out_tree_u),
    .out_tree_v         (out_tree_v),
    .out_tree_cost      (out_tree_cost)
  );

  kruskal_edge_acceptance_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_vertex_u        (in_vertex_u),
    .in_vertex_v        (in_vertex_v),
    .in_edge_cost       (in_edge_cost),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_components_left(out_components_left),
    .out_tree_u         (out_tree_u),
    .out_tree_v         (out_tree_v),
    .out_tree_cost      (out_tree_cost),
    .mismatch_count     (mismatch_count),
    .words_pending      (words_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  always begin : result_sink
    @(posedge clk);
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      out_ready <= 1'b0;
      repeat (LONG_HOLD_CYCLES) @(posedge clk);
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic offer(input logic mode, input logic [VERTEX_W-1:0] u,
                       input logic [VERTEX_W-1:0] v, input logic [COST_W-1:0] cost);
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_vertex_u  <= u;
    in_vertex_v  <= v;
    in_edge_cost <= cost;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [COUNT_W-1:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_VERTEX_COUNT;
    pwdata  <= ($urandom() & ~32'h7F) | {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    vertices_in_use = int'(value);
    if (vertices_in_use < 2) vertices_in_use = 2;
    if (vertices_in_use > MAX_VERTICES) vertices_in_use = MAX_VERTICES;
  endtask

  initial begin : stimulus
    int sent;
    int phase;
    int phase_len;
    int r;
    bit calm;
    logic [COUNT_W-1:0]  wv;
    logic [VERTEX_W-1:0] u;
    logic [VERTEX_W-1:0] v;
    logic [COST_W-1:0]   cost_run;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);

    // directed words
    tx_gap_pct   = 30;
    rx_stall_pct = 30;
    offer(MODE_EDGE, 6'd0, 6'd63, 32'h8000_0000);
    offer(MODE_EDGE, 6'd5, 6'd5, 32'hFFFF_FFFF);
    offer(MODE_EDGE, 6'd63, 6'd0, 32'h0000_0000);
    offer(MODE_EDGE, 6'd1, 6'd2, 32'd1);
    offer(MODE_EDGE, 6'd3, 6'd4, 32'd2);
    offer(MODE_EDGE, 6'd1, 6'd3, 32'd3);
    offer(MODE_EDGE, 6'd2, 6'd4, 32'd4);
    offer(MODE_RESTART, 6'd63, 6'd63, 32'h7FFF_FFFF);
    set_vertex_count(7'd10);
    offer(MODE_EDGE, 6'd10, 6'd3, 32'd5);
    offer(MODE_EDGE, 6'd3, 6'd63, 32'd6);
    offer(MODE_EDGE, 6'd9, 6'd0, 32'd7);
    set_vertex_count(7'd0);
    offer(MODE_EDGE, 6'd1, 6'd0, 32'd8);
    offer(MODE_EDGE, 6'd2, 6'd0, 32'd9);
    offer(MODE_RESTART, 6'd0, 6'd0, 32'h0000_0000);
    offer(MODE_EDGE, 6'd0, 6'd1, 32'd10);
    offer(MODE_EDGE, 6'd0, 6'd1, 32'd11);
    offer(MODE_EDGE, 6'd63, 6'd63, 32'd12);
    offer(MODE_EDGE, 6'd0, 6'd0, 32'd13);
    set_vertex_count(7'd127);
    offer(MODE_RESTART, 6'd21, 6'd42, 32'h5555_AAAA);
    offer(MODE_EDGE, 6'd0, 6'd63, 32'h7FFF_FFFF);
    offer(MODE_EDGE, 6'd63, 6'd62, 32'h7FFF_FFFF);
    set_vertex_count(7'd1);
    offer(MODE_RESTART, 6'd1, 6'd0, 32'hAAAA_5555);
    offer(MODE_EDGE, 6'd1, 6'd0, 32'h8000_0000);

    // random phases: each starts from a restart and builds a spanning forest
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      calm = (sent >= RANDOM_WORDS - CALM_WORDS);
      tx_gap_pct   = calm ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(5, 40));
      rx_stall_pct = calm ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(5, 40));
      if (!calm) begin
        if (phase == 0 || $urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 7))
            0:       wv = COUNT_W'($urandom_range(0, 1));
            1:       wv = 7'd2;
            2:       wv = COUNT_W'($urandom_range(3, 8));
            3, 4:    wv = COUNT_W'($urandom_range(9, 20));
            5:       wv = COUNT_W'($urandom_range(21, 63));
            6:       wv = 7'd64;
            default: wv = COUNT_W'($urandom_range(65, 127));
          endcase
          set_vertex_count(wv);
        end else if (phase % 5 == 4) begin
          wait_drained();
        end
      end
      phase_len = $urandom_range(vertices_in_use, 3 * vertices_in_use);
      if (phase == 1) begin
        // long hold-off on the result side while words keep coming
        tx_gap_pct    = 0;
        long_hold_req = 1'b1;
        if (phase_len < 24) phase_len = 24;
      end
      cost_run = $urandom();
      offer(MODE_RESTART, VERTEX_W'($urandom_range(0, 63)), VERTEX_W'($urandom_range(0, 63)),
            $urandom());
      sent++;
      for (int k = 0; k < phase_len; k++) begin
        r = $urandom_range(0, 99);
        cost_run = cost_run + $urandom_range(0, 255);
        if (r < 3) begin
          offer(MODE_RESTART, VERTEX_W'($urandom_range(0, 63)),
                VERTEX_W'($urandom_range(0, 63)), $urandom());
        end else begin
          if (r < 9) begin
            u = VERTEX_W'($urandom_range(0, 63));
            v = VERTEX_W'($urandom_range(0, 63));
          end else if (r < 12) begin
            u = VERTEX_W'($urandom_range(0, vertices_in_use - 1));
            v = u;
          end else begin
            u = VERTEX_W'($urandom_range(0, vertices_in_use - 1));
            v = VERTEX_W'($urandom_range(0, vertices_in_use - 1));
          end
          offer(MODE_EDGE, u, v, cost_run);
        end
        sent++;
      end
      phase++;
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
